// ----- src/pfm_pkg.sv -----
// package for the packet flow meter with source block list
// constants, item types and helper functions; no dependencies
`default_nettype none
package pfm_pkg;

    localparam int FLOW_ENTRIES  = 1024;
    localparam int FLOW_WAYS     = 4;
    localparam int BLOCK_ENTRIES = 256;
    localparam int BLOCK_WAYS    = 4;

    localparam int FLOW_SETS  = FLOW_ENTRIES / FLOW_WAYS;
    localparam int BLOCK_SETS = BLOCK_ENTRIES / BLOCK_WAYS;
    localparam int FSET_W = (FLOW_SETS > 1) ? $clog2(FLOW_SETS) : 1;
    localparam int BSET_W = (BLOCK_SETS > 1) ? $clog2(BLOCK_SETS) : 1;
    localparam int FWAY_W = (FLOW_WAYS > 1) ? $clog2(FLOW_WAYS) : 1;
    localparam int BWAY_W = (BLOCK_WAYS > 1) ? $clog2(BLOCK_WAYS) : 1;
    localparam int TREE_LEAVES = (FLOW_WAYS > 4) ? 8 : (FLOW_WAYS > 2) ? 4 :
                                 (FLOW_WAYS > 1) ? 2 : 1;
    localparam int TREE_LVLS = (TREE_LEAVES > 1) ? $clog2(TREE_LEAVES) : 0;

    // per-set metadata: valid bits of all ways and the replacement tree
    localparam int PLRU_W   = 8;
    localparam int FMETA_W  = FLOW_WAYS + PLRU_W;
    localparam int CLR_SETS = (FLOW_SETS > BLOCK_SETS) ? FLOW_SETS : BLOCK_SETS;
    localparam int CLR_W    = (CLR_SETS > 1) ? $clog2(CLR_SETS) : 1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        RK_PASS     = 3'd0,
        RK_EVENT    = 3'd1,
        RK_DROP     = 3'd2,
        RK_INSERTED = 3'd3,
        RK_FULL     = 3'd4,
        RK_QHIT     = 3'd5,
        RK_QMISS    = 3'd6
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [63:0] arrival_ns;
        logic [3:0]  tcp_flag_bits;
        logic [15:0] l4_dst_port;
        logic [15:0] l4_src_port;
        logic [15:0] ip_total_len;
        logic [7:0]  ip_proto;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [15:0] ether_type;
        logic [15:0] frame_len;
        logic [1:0]  opcode;
    } item_t;

    typedef struct packed {
        logic [31:0] blocked_total;
        logic [63:0] flag_totals;
        logic [63:0] last_seen_ns;
        logic [63:0] first_seen_ns;
        logic [31:0] packet_total;
        logic [63:0] byte_total;
        logic [15:0] ev_dst_port;
        logic [15:0] ev_src_port;
        logic [7:0]  ev_protocol;
        logic [31:0] ev_dst_addr;
        logic [31:0] ev_src_addr;
        logic [2:0]  result_kind;
    } result_t;

    // one flow entry as stored in a way
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [63:0] bytes;
        logic [31:0] packets;
        logic [63:0] start;
        logic [63:0] last;
        logic [63:0] flags;
    } flow_ent_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] count;
    } blk_ent_t;

    localparam int FLOW_ENT_W = $bits(flow_ent_t);
    localparam int BLK_ENT_W  = $bits(blk_ent_t);

    function automatic logic [31:0] fold_key(input logic [31:0] k);
        return k ^ (k >> 11) ^ (k >> 22);
    endfunction

    function automatic logic [63:0] add_flags(input logic [63:0] f, input logic [3:0] bits);
        logic [63:0] r;
        r = f;
        for (int i = 0; i < 4; i++) begin
            if (bits[i] && (f[16*i +: 16] != 16'hFFFF))
                r[16*i +: 16] = f[16*i +: 16] + 16'd1;
        end
        return r;
    endfunction

    function automatic logic [FWAY_W-1:0] tree_victim(input logic [7:0] plru);
        logic [4:0] node;
        node = 5'd1;
        for (int l = 0; l < TREE_LVLS; l++)
            node = {node[3:0], plru[3'(node - 5'd1)]};
        return FWAY_W'((node - 5'(TREE_LEAVES)) % 5'(FLOW_WAYS));
    endfunction

    function automatic logic [7:0] tree_touch(input logic [7:0] plru,
                                              input logic [FWAY_W-1:0] way);
        logic [7:0] r;
        logic [4:0] node;
        logic [4:0] parent;
        r = plru;
        node = 5'(way) + 5'(TREE_LEAVES);
        for (int l = 0; l < TREE_LVLS; l++) begin
            parent = node >> 1;
            r[3'(parent - 5'd1)] = ~node[0];
            node = parent;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/pfm_ram.sv -----
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module pfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- src/pfm_valid.sv -----
// per-set valid bits of the flow and block tables and the flow table's replacement trees
// held in set memories and zeroed by a clearing pass after reset; depends on pfm_pkg, pfm_ram
`default_nettype none
module pfm_valid
    import pfm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    output logic                    busy,
    input  wire logic [FSET_W-1:0]  frd_set,
    output logic      [FMETA_W-1:0] frd_data,
    input  wire logic               fwr_en,
    input  wire logic [FSET_W-1:0]  fwr_set,
    input  wire logic [FMETA_W-1:0] fwr_data,
    input  wire logic [BSET_W-1:0]  brd_set,
    output logic [BLOCK_WAYS-1:0]   brd_data,
    input  wire logic               bwr_en,
    input  wire logic [BSET_W-1:0]  bwr_set,
    input  wire logic [BLOCK_WAYS-1:0] bwr_data
);
    logic             busy_reg;
    logic [CLR_W-1:0] clr_idx_reg;

    logic                  f_en, b_en;
    logic [FSET_W-1:0]     f_addr;
    logic [BSET_W-1:0]     b_addr;
    logic [FMETA_W-1:0]    f_data;
    logic [BLOCK_WAYS-1:0] b_data;

    // one set of each table per cycle until all sets read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_idx_reg == CLR_W'(CLR_SETS - 1))
                busy_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign busy   = busy_reg;
    assign f_en   = busy_reg ? (32'(clr_idx_reg) < FLOW_SETS) : fwr_en;
    assign b_en   = busy_reg ? (32'(clr_idx_reg) < BLOCK_SETS) : bwr_en;
    assign f_addr = busy_reg ? FSET_W'(clr_idx_reg) : fwr_set;
    assign b_addr = busy_reg ? BSET_W'(clr_idx_reg) : bwr_set;
    assign f_data = busy_reg ? '0 : fwr_data;
    assign b_data = busy_reg ? '0 : bwr_data;

    pfm_ram #(.WIDTH(FMETA_W), .DEPTH(FLOW_SETS)) u_fmeta_ram (
        .clk(clk), .wr_en(f_en), .wr_addr(f_addr), .wr_data(f_data),
        .rd_addr(frd_set), .rd_data(frd_data));
    pfm_ram #(.WIDTH(BLOCK_WAYS), .DEPTH(BLOCK_SETS)) u_bmeta_ram (
        .clk(clk), .wr_en(b_en), .wr_addr(b_addr), .wr_data(b_data),
        .rd_addr(brd_set), .rd_data(brd_data));
endmodule
`default_nettype wire

// ----- src/packet_flow_meter_blocklist.sv -----
// top level: per-source flow meter with source-address block list
// depends on pfm_pkg, pfm_ram, pfm_valid
//
// usage: items enter on the s_axis group, one result item per input item
// leaves on the m_axis group. an item is accepted when tvalid and tready are
// both high. the block works on one item at a time: the accepting edge latches
// the item and presents the set addresses to the flow and block memories, the
// next cycle sees the registered read data of all ways, decides, and writes
// the set back; the result is loaded into the output register. m_axis_tvalid
// rises when the decision cycle loads the output register; s_axis_tready is
// low in the decision cycle, so a new item is taken only once the last one
// has been decided.
// after reset a clearing pass zeroes the valid bits and replacement trees of
// every set, one set per cycle, with s_axis_tready low. a stalled receiver
// holds the result in place; one more item is taken and waits in its decision
// cycle until the output register is free, and input stops meanwhile.
// flow and block entries sit in set-wide memories, one row per set, holding
// all ways side by side; valid and pseudo-lru bits sit in their own set memories.
`default_nettype none
module packet_flow_meter_blocklist
    import pfm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // fields from bit 0: frame_len, ether_type, src_addr, dst_addr, ip_proto,
    // ip_total_len, l4_src_port, l4_dst_port, tcp_flag_bits, arrival_ns
    input  wire logic [223:0] s_axis_tdata,
    // opcode
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // fields from bit 0: ev_src_addr, ev_dst_addr, ev_protocol, ev_src_port,
    // ev_dst_port, byte_total, packet_total, first_seen_ns, last_seen_ns,
    // flag_totals, blocked_total
    output logic [423:0]      m_axis_tdata,
    // result_kind
    output logic [2:0]        m_axis_tuser
);
    localparam int FROW_W = FLOW_WAYS * (FLOW_ENT_W - 1);
    localparam int BROW_W = BLOCK_WAYS * (BLK_ENT_W - 1);
    localparam int FDATA_W = FLOW_ENT_W - 1;
    localparam int BDATA_W = BLK_ENT_W - 1;

    state_t state_reg, state_next;
    item_t  item_reg;
    result_t res_reg;
    logic   res_valid_reg;
    logic   clr_busy;

    item_t in_item;
    assign in_item = item_t'({s_axis_tdata[219:0], s_axis_tuser});

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // set indices of the incoming item, used as read address
    logic [31:0] in_fold;
    logic [FSET_W-1:0] in_fset, fset, fset_rd;
    logic [BSET_W-1:0] in_bset, bset, bset_rd;
    assign in_fold = fold_key(in_item.src_addr);
    assign in_fset = FSET_W'(in_fold % 32'(FLOW_SETS));
    assign in_bset = BSET_W'(in_fold % 32'(BLOCK_SETS));
    assign fset = FSET_W'(fold_key(item_reg.src_addr) % 32'(FLOW_SETS));
    assign bset = BSET_W'(fold_key(item_reg.src_addr) % 32'(BLOCK_SETS));
    // keep reading the latched item's set while it waits for the output
    assign fset_rd = (state_reg == ST_IDLE) ? in_fset : fset;
    assign bset_rd = (state_reg == ST_IDLE) ? in_bset : bset;

    logic [FROW_W-1:0] frow_rd, frow_wr;
    logic [BROW_W-1:0] brow_rd, brow_wr;
    logic [FLOW_WAYS-1:0] fval_rd, fval_wr;
    logic [BLOCK_WAYS-1:0] bval_rd, bval_wr;
    logic [FMETA_W-1:0] fmeta_rd;
    logic fwr_en, bwr_en;
    logic [7:0] plru_rd, plru_new;

    assign fval_rd = fmeta_rd[FLOW_WAYS-1:0];
    assign plru_rd = fmeta_rd[FLOW_WAYS +: PLRU_W];

    pfm_ram #(.WIDTH(FROW_W), .DEPTH(FLOW_SETS)) u_flow_ram (
        .clk(clk), .wr_en(fwr_en), .wr_addr(fset), .wr_data(frow_wr),
        .rd_addr(fset_rd), .rd_data(frow_rd));
    pfm_ram #(.WIDTH(BROW_W), .DEPTH(BLOCK_SETS)) u_blk_ram (
        .clk(clk), .wr_en(bwr_en), .wr_addr(bset), .wr_data(brow_wr),
        .rd_addr(bset_rd), .rd_data(brow_rd));
    pfm_valid u_meta (
        .clk(clk), .rst_n(rst_n), .busy(clr_busy),
        .frd_set(fset_rd), .frd_data(fmeta_rd),
        .fwr_en(fwr_en), .fwr_set(fset), .fwr_data({plru_new, fval_wr}),
        .brd_set(bset_rd), .brd_data(bval_rd),
        .bwr_en(bwr_en), .bwr_set(bset), .bwr_data(bval_wr));

    // decision, done in ST_LOOKUP when the output register is free
    result_t res_calc;
    logic    out_free;
    assign out_free = !res_valid_reg || m_axis_tready;

    always_comb
    begin
        flow_ent_t fe [FLOW_WAYS];
        blk_ent_t  be [BLOCK_WAYS];
        logic bhit, fhit, ffound, bfree_found;
        logic [BWAY_W-1:0] bway, bfree;
        logic [FWAY_W-1:0] fway;
        logic [63:0] nb;
        logic [3:0]  fb;
        logic        pkt_ok;
        flow_ent_t   ne;

        for (int w = 0; w < FLOW_WAYS; w++)
            fe[w] = flow_ent_t'({fval_rd[w], frow_rd[w*FDATA_W +: FDATA_W]});
        for (int w = 0; w < BLOCK_WAYS; w++)
            be[w] = blk_ent_t'({bval_rd[w], brow_rd[w*BDATA_W +: BDATA_W]});

        res_calc = '0;
        frow_wr = frow_rd;
        brow_wr = brow_rd;
        fval_wr = fval_rd;
        bval_wr = bval_rd;
        fwr_en = 1'b0;
        bwr_en = 1'b0;
        plru_new = plru_rd;
        bhit = 1'b0; bway = '0; bfree_found = 1'b0; bfree = '0;
        fhit = 1'b0; ffound = 1'b0; fway = '0;
        nb = '0; ne = '0;
        fb = item_reg.tcp_flag_bits;

        for (int w = BLOCK_WAYS - 1; w >= 0; w--)
        begin
            if (be[w].valid && be[w].key == item_reg.src_addr)
            begin
                bhit = 1'b1;
                bway = BWAY_W'(w);
            end
            if (!be[w].valid)
            begin
                bfree_found = 1'b1;
                bfree = BWAY_W'(w);
            end
        end

        pkt_ok = (item_reg.frame_len >= 16'd34) && (item_reg.ether_type == ETHERTYPE_IPV4);
        if (state_reg == ST_LOOKUP && out_free)
        begin
            unique case (item_reg.opcode)
                OP_INSERT, OP_QUERY:
                begin
                    res_calc.ev_src_addr = item_reg.src_addr;
                    if (bhit)
                    begin
                        res_calc.result_kind = (item_reg.opcode == OP_INSERT) ?
                                               RK_INSERTED : RK_QHIT;
                        res_calc.blocked_total = be[bway].count;
                    end
                    else if (item_reg.opcode == OP_QUERY)
                        res_calc.result_kind = RK_QMISS;
                    else if (bfree_found)
                    begin
                        res_calc.result_kind = RK_INSERTED;
                        bwr_en = 1'b1;
                        bval_wr[bfree] = 1'b1;
                        brow_wr[32'(bfree)*BDATA_W +: BDATA_W] = {item_reg.src_addr, 32'd0};
                    end
                    else
                        res_calc.result_kind = RK_FULL;
                end
                OP_PACKET:
                begin
                    if (pkt_ok && bhit)
                    begin
                        res_calc.result_kind = RK_DROP;
                        res_calc.ev_src_addr = item_reg.src_addr;
                        res_calc.blocked_total = (be[bway].count == 32'hFFFF_FFFF) ?
                            be[bway].count : be[bway].count + 32'd1;
                        bwr_en = 1'b1;
                        brow_wr[32'(bway)*BDATA_W +: BDATA_W] =
                            {item_reg.src_addr, res_calc.blocked_total};
                    end
                    else if (pkt_ok &&
                             ((item_reg.ip_proto == PROTO_TCP && item_reg.frame_len >= 16'd54) ||
                              (item_reg.ip_proto == PROTO_UDP && item_reg.frame_len >= 16'd42)))
                    begin
                        if (item_reg.ip_proto == PROTO_UDP)
                            fb = '0;
                        for (int w = FLOW_WAYS - 1; w >= 0; w--)
                        begin
                            if (fe[w].valid && fe[w].key == item_reg.src_addr)
                            begin
                                fhit = 1'b1;
                                fway = FWAY_W'(w);
                            end
                        end
                        if (!fhit)
                        begin
                            for (int w = FLOW_WAYS - 1; w >= 0; w--)
                            begin
                                if (!fe[w].valid)
                                begin
                                    ffound = 1'b1;
                                    fway = FWAY_W'(w);
                                end
                            end
                            if (!ffound)
                                fway = tree_victim(plru_rd);
                        end
                        if (fhit)
                        begin
                            ne = fe[fway];
                            nb = fe[fway].bytes + 64'(item_reg.ip_total_len);
                            ne.bytes = (nb < fe[fway].bytes) ? 64'hFFFF_FFFF_FFFF_FFFF : nb;
                            if (ne.packets != 32'hFFFF_FFFF)
                                ne.packets = ne.packets + 32'd1;
                            ne.last = item_reg.arrival_ns;
                            ne.flags = add_flags(fe[fway].flags, fb);
                        end
                        else
                        begin
                            ne.valid = 1'b1;
                            ne.key = item_reg.src_addr;
                            ne.bytes = 64'(item_reg.ip_total_len);
                            ne.packets = 32'd1;
                            ne.start = item_reg.arrival_ns;
                            ne.last = item_reg.arrival_ns;
                            ne.flags = add_flags(64'd0, fb);
                        end
                        fwr_en = 1'b1;
                        fval_wr[fway] = 1'b1;
                        frow_wr[32'(fway)*FDATA_W +: FDATA_W] = ne[FDATA_W-1:0];
                        plru_new = tree_touch(plru_rd, fway);
                        res_calc.result_kind = RK_EVENT;
                        res_calc.ev_src_addr = item_reg.src_addr;
                        res_calc.ev_dst_addr = item_reg.dst_addr;
                        res_calc.ev_protocol = item_reg.ip_proto;
                        res_calc.ev_src_port = item_reg.l4_src_port;
                        res_calc.ev_dst_port = item_reg.l4_dst_port;
                        res_calc.byte_total = ne.bytes;
                        res_calc.packet_total = ne.packets;
                        res_calc.first_seen_ns = ne.start;
                        res_calc.last_seen_ns = ne.last;
                        res_calc.flag_totals = ne.flags;
                    end
                end
                default: res_calc = '0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (!clr_busy) state_next = ST_IDLE;
            ST_IDLE:   if (in_fire) state_next = ST_LOOKUP;
            ST_LOOKUP: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_LOOKUP && out_free)
                res_valid_reg <= 1'b1;
            else if (m_axis_tready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_item;
        if (state_reg == ST_LOOKUP && out_free)
            res_reg <= res_calc;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_reg.result_kind;
    assign m_axis_tdata  = res_reg[$bits(result_t)-1:3];
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// testbench for packet_flow_meter_blocklist: random and directed items with an
// in-bench flow and block table predictor; depends on pfm_pkg and the rtl
`timescale 1ns / 1ps
module tb_top;
    import pfm_pkg::*;

    typedef struct {
        opcode_t     op;
        logic [15:0] frame_len;
        logic [15:0] ether_type;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ip_proto;
        logic [15:0] ip_total_len;
        logic [15:0] l4_src_port;
        logic [15:0] l4_dst_port;
        logic [3:0]  tcp_flag_bits;
        logic [63:0] arrival_ns;
    } hdr_t;

    typedef struct {
        logic [2:0]   kind;
        logic [423:0] payload;
    } verdict_t;

    // flow and block table shadow plus the queue of expected results
    class meter_scoreboard;
        bit          fv[FLOW_ENTRIES];
        logic [31:0] fkey[FLOW_ENTRIES];
        logic [63:0] fbytes[FLOW_ENTRIES];
        logic [31:0] fpkts[FLOW_ENTRIES];
        logic [63:0] fstart[FLOW_ENTRIES];
        logic [63:0] flast[FLOW_ENTRIES];
        logic [63:0] fflags[FLOW_ENTRIES];
        logic [7:0]  plru[FLOW_SETS];
        bit          bv[BLOCK_ENTRIES];
        logic [31:0] bkey[BLOCK_ENTRIES];
        logic [31:0] bcnt[BLOCK_ENTRIES];
        verdict_t    pending[$];
        int          mismatches;

        function int set_of(logic [31:0] k, int sets);
            logic [31:0] f;
            f = k ^ (k >> 11) ^ (k >> 22);
            return f % sets;
        endfunction

        function int find_block(logic [31:0] k);
            int b;
            b = set_of(k, BLOCK_SETS) * BLOCK_WAYS;
            for (int w = 0; w < BLOCK_WAYS; w++)
                if (bv[b + w] && bkey[b + w] == k) return b + w;
            return -1;
        endfunction

        function logic [63:0] bump_flags(logic [63:0] f, logic [3:0] bits);
            for (int i = 0; i < 4; i++)
                if (bits[i] && f[16*i +: 16] != 16'hFFFF) f[16*i +: 16] += 16'd1;
            return f;
        endfunction

        function int lru_way(int s);
            int node;
            node = 1;
            while (node < TREE_LEAVES) node = 2 * node + plru[s][(node - 1) & 7];
            return (node - TREE_LEAVES) % FLOW_WAYS;
        endfunction

        function void mark_used(int s, int w);
            int node;
            node = w + TREE_LEAVES;
            while (node > 1) begin
                plru[s][((node >> 1) - 1) & 7] = ~node[0];
                node = node >> 1;
            end
        endfunction

        function void note_item(hdr_t h);
            verdict_t v;
            int b, s, base, w, e;
            bit hit;
            logic [3:0] fb;
            logic [64:0] sum;
            v.kind = RK_PASS;
            v.payload = '0;
            if (h.op == OP_INSERT || h.op == OP_QUERY) begin
                v.payload[31:0] = h.src_addr;
                b = find_block(h.src_addr);
                if (b >= 0) begin
                    v.kind = (h.op == OP_INSERT) ? RK_INSERTED : RK_QHIT;
                    v.payload[423:392] = bcnt[b];
                end else if (h.op == OP_QUERY) begin
                    v.kind = RK_QMISS;
                end else begin
                    v.kind = RK_FULL;
                    base = set_of(h.src_addr, BLOCK_SETS) * BLOCK_WAYS;
                    for (w = 0; w < BLOCK_WAYS; w++)
                        if (!bv[base + w]) begin
                            bv[base + w] = 1;
                            bkey[base + w] = h.src_addr;
                            bcnt[base + w] = 0;
                            v.kind = RK_INSERTED;
                            break;
                        end
                end
            end else if (h.op == OP_PACKET && h.ether_type == ETHERTYPE_IPV4 &&
                         h.frame_len >= 34) begin
                b = find_block(h.src_addr);
                fb = h.tcp_flag_bits;
                if (b >= 0) begin
                    if (bcnt[b] != '1) bcnt[b]++;
                    v.kind = RK_DROP;
                    v.payload[31:0] = h.src_addr;
                    v.payload[423:392] = bcnt[b];
                end else if ((h.ip_proto == PROTO_TCP && h.frame_len >= 54) ||
                             (h.ip_proto == PROTO_UDP && h.frame_len >= 42)) begin
                    if (h.ip_proto == PROTO_UDP) fb = 0;
                    s = set_of(h.src_addr, FLOW_SETS);
                    base = s * FLOW_WAYS;
                    hit = 0;
                    w = 0;
                    for (int i = 0; i < FLOW_WAYS; i++)
                        if (fv[base + i] && fkey[base + i] == h.src_addr) begin
                            hit = 1;
                            w = i;
                            break;
                        end
                    if (hit) begin
                        e = base + w;
                        sum = {1'b0, fbytes[e]} + h.ip_total_len;
                        fbytes[e] = sum[64] ? '1 : sum[63:0];
                        if (fpkts[e] != '1) fpkts[e]++;
                        flast[e] = h.arrival_ns;
                        fflags[e] = bump_flags(fflags[e], fb);
                    end else begin
                        w = -1;
                        for (int i = 0; i < FLOW_WAYS; i++)
                            if (!fv[base + i]) begin
                                w = i;
                                break;
                            end
                        if (w < 0) w = lru_way(s);
                        e = base + w;
                        fv[e] = 1;
                        fkey[e] = h.src_addr;
                        fbytes[e] = 64'(h.ip_total_len);
                        fpkts[e] = 1;
                        fstart[e] = h.arrival_ns;
                        flast[e] = h.arrival_ns;
                        fflags[e] = bump_flags('0, fb);
                    end
                    mark_used(s, w);
                    v.kind = RK_EVENT;
                    v.payload = {32'd0, fflags[e], flast[e], fstart[e], fpkts[e], fbytes[e],
                                 h.l4_dst_port, h.l4_src_port, h.ip_proto, h.dst_addr,
                                 h.src_addr};
                end
            end
            pending.push_back(v);
        endfunction

        function void check_result(logic [2:0] kind, logic [423:0] data);
            verdict_t v;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item kind %0d", kind);
                return;
            end
            v = pending.pop_front();
            if (kind !== v.kind || data !== v.payload) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: kind exp %0d got %0d\n exp %h\n got %h",
                             v.kind, kind, v.payload, data);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [423:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    meter_scoreboard meter;
    bit              calm;
    bit              sending_done;
    logic [31:0]     hot_src[16];

    packet_flow_meter_blocklist dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // send one item, holding tvalid across back-to-back items
    task automatic send_item(hdr_t h);
        while (!calm && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= h.op;
        s_axis_tdata  <= {4'd0, h.arrival_ns, h.tcp_flag_bits, h.l4_dst_port,
                          h.l4_src_port, h.ip_total_len, h.ip_proto, h.dst_addr,
                          h.src_addr, h.ether_type, h.frame_len};
        do @(posedge clk); while (!s_axis_tready);
        meter.note_item(h);
    endtask

    function automatic hdr_t random_item();
        hdr_t h;
        int r;
        h.op = OP_PACKET;
        h.frame_len = 16'($urandom_range(54, 1514));
        h.ether_type = ETHERTYPE_IPV4;
        // small address pool so flows hit, collide and get evicted
        h.src_addr = ($urandom_range(3) == 0) ? $urandom() : hot_src[$urandom_range(15)];
        h.dst_addr = $urandom();
        h.ip_proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        h.ip_total_len = 16'($urandom());
        h.l4_src_port = 16'($urandom());
        h.l4_dst_port = 16'($urandom());
        h.tcp_flag_bits = 4'($urandom());
        h.arrival_ns = {$urandom(), $urandom()};
        r = $urandom_range(99);
        if (r < 6) h.op = OP_INSERT;
        else if (r < 12) h.op = OP_QUERY;
        else if (r < 14) h.op = OP_NONE;
        else if (r < 17) h.frame_len = 16'($urandom());
        else if (r < 20) h.ether_type = 16'($urandom());
        else if (r < 23) h.ip_proto = 8'($urandom());
        else if (r < 26) h.frame_len = 16'($urandom_range(34, 53));
        return h;
    endfunction

    function automatic hdr_t base_pkt(logic [31:0] src);
        hdr_t h;
        h = '{OP_PACKET, 16'd60, ETHERTYPE_IPV4, src, 32'h0A000001, PROTO_TCP, 16'd40,
              16'd1234, 16'd80, 4'h3, 64'd1000};
        return h;
    endfunction

    initial
    begin
        hdr_t h;
        logic [31:0] same_set[6];
        meter = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_PACKET;
        calm = 1'b0;
        sending_done = 1'b0;
        for (int i = 0; i < 16; i++) hot_src[i] = $urandom();
        // keys sharing flow set 0 and block set 0: k = n<<22 | n folds to zero low bits
        for (int i = 0; i < 6; i++) same_set[i] = ((i + 1) << 22) | (i + 1);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        h = base_pkt(32'hC0A80001);
        send_item(h);
        h.arrival_ns = '1; h.ip_total_len = 16'hFFFF; h.tcp_flag_bits = 4'hF;
        send_item(h);
        h = base_pkt(32'hFFFFFFFF); h.ip_proto = PROTO_UDP; h.frame_len = 16'd42;
        h.dst_addr = '1; h.l4_src_port = '1; h.l4_dst_port = '1;
        send_item(h);
        h.frame_len = 16'd41; send_item(h);
        h = base_pkt(32'd0); h.frame_len = 16'd53; send_item(h);
        h.frame_len = 16'd13; send_item(h);
        h.frame_len = 16'd33; send_item(h);
        h.frame_len = 16'hFFFF; h.ether_type = 16'h86DD; send_item(h);
        h.ether_type = ETHERTYPE_IPV4; h.ip_proto = 8'd1; send_item(h);
        for (int i = 0; i < 6; i++) send_item(base_pkt(same_set[i]));
        send_item(base_pkt(same_set[0]));
        h = base_pkt(32'hC0A80001); h.op = OP_QUERY; send_item(h);
        h.op = OP_INSERT; send_item(h);
        send_item(h);
        h.op = OP_QUERY; send_item(h);
        // blocked source drops even if not tcp or udp
        h = base_pkt(32'hC0A80001); h.ip_proto = 8'd1; h.frame_len = 16'd34; send_item(h);
        for (int i = 0; i < 5; i++)
        begin
            h = base_pkt(same_set[i]); h.op = OP_INSERT; send_item(h);
        end
        h.op = OP_NONE; h.frame_len = '1; send_item(h);

        // random part, with a stretch free of idling in the middle
        for (int n = 0; n < 1550; n++)
        begin
            calm = (n >= 600 && n < 800);
            send_item(random_item());
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // receive side with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                meter.check_result(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    initial
    begin
        wait (sending_done);
        while (meter.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (meter.mismatches == 0 && meter.pending.size() == 0)
            $display("PASS packet_flow_meter_blocklist");
        else
            $display("FAIL packet_flow_meter_blocklist");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL packet_flow_meter_blocklist");
        $finish;
    end
endmodule

// ----- sim.f -----
src/pfm_pkg.sv
src/pfm_ram.sv
src/pfm_valid.sv
src/packet_flow_meter_blocklist.sv
bench/tb_top.sv
